@@ sv/segment_tree_range_sum_core_defines.svh @@
// Assertion macros shared by the segment tree range sum core.
`ifndef SEGMENT_TREE_RANGE_SUM_CORE_DEFINES_SVH
`define SEGMENT_TREE_RANGE_SUM_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define STSUM_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define STSUM_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/stsum_pkg.sv @@
// Types, codes and constants shared by the segment tree range sum core.
package stsum_pkg;

    localparam int unsigned DEF_MAX_LEAVES = 1024;
    localparam int OPCODE_W   = 2;
    localparam int POS_W      = 10;
    localparam int RB_W       = 11;
    localparam int VAL_W      = 32;
    localparam int CFG_W      = 11;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_BUILD  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]     opcode;
        logic [POS_W-1:0]        position;
        logic [RB_W-1:0]         right_bound;
        logic signed [VAL_W-1:0] leaf_value;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] range_sum;
        logic                    error;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_LEAF_WR,
        ST_MOD_RD,
        ST_MOD_UP,
        ST_BLD_CHK,
        ST_BLD_RDL,
        ST_BLD_RDR,
        ST_BLD_WR,
        ST_QRY_A,
        ST_QRY_B,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        L_HOLD,
        L_LEAF,
        L_BUILD,
        L_INC,
        L_DEC,
        L_HALF
    } l_op_t;

    typedef enum logic [1:0] {
        R_HOLD,
        R_QRIGHT,
        R_HALF
    } r_op_t;

    typedef enum logic [1:0] {
        MEM_NONE,
        MEM_RD,
        MEM_WR
    } mem_op_t;

    typedef enum logic [2:0] {
        ADDR_L,
        ADDR_SIB,
        ADDR_CHILD_L,
        ADDR_CHILD_R,
        ADDR_PARENT,
        ADDR_R_EVEN
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_ZERO,
        WD_VAL,
        WD_SUM
    } wd_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_ZERO,
        ACC_VAL,
        ACC_RD,
        ACC_ADD_RD,
        ACC_ADD_PEND
    } acc_op_t;

    typedef struct packed {
        logic      item_load;
        l_op_t     l_op;
        r_op_t     r_op;
        mem_op_t   mem_op;
        addr_sel_t addr_sel;
        wd_sel_t   wd_sel;
        acc_op_t   acc_op;
        logic      res_load;
        logic      res_sum;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic item_err;
        logic l_gt1;
        logic l_gt3;
        logic l_zero;
        logic l_eq1;
        logic l_lt_r;
        logic l_odd;
        logic r_odd;
        logic clr_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ sv/stsum_ctrl.sv @@
// Controller state machine that sequences the node store accesses for each operation.
`include "segment_tree_range_sum_core_defines.svh"

module stsum_ctrl
    import stsum_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (status.op) inside
                    OP_LOAD, OP_MODIFY: begin
                        state_next = status.item_err ? ST_FINISH : ST_LEAF_WR;
                    end
                    OP_BUILD: begin
                        state_next = ST_BLD_CHK;
                    end
                    OP_QUERY: begin
                        state_next = status.item_err ? ST_FINISH : ST_QRY_A;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_LEAF_WR: begin
                if (status.op == OP_MODIFY && status.l_gt1) begin
                    state_next = ST_MOD_RD;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_MOD_RD: begin
                state_next = ST_MOD_UP;
            end
            ST_MOD_UP: begin
                // The pointer halves in this cycle, so test the level above.
                state_next = status.l_gt3 ? ST_MOD_RD : ST_FINISH;
            end
            ST_BLD_CHK: begin
                state_next = status.l_zero ? ST_FINISH : ST_BLD_RDL;
            end
            ST_BLD_RDL: begin
                state_next = ST_BLD_RDR;
            end
            ST_BLD_RDR: begin
                state_next = ST_BLD_WR;
            end
            ST_BLD_WR: begin
                state_next = status.l_eq1 ? ST_FINISH : ST_BLD_RDL;
            end
            ST_QRY_A: begin
                state_next = status.l_lt_r ? ST_QRY_B : ST_FINISH;
            end
            ST_QRY_B: begin
                state_next = ST_QRY_A;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.item_load = 1'b0;
        cmd.l_op      = L_HOLD;
        cmd.r_op      = R_HOLD;
        cmd.mem_op    = MEM_NONE;
        cmd.addr_sel  = ADDR_L;
        cmd.wd_sel    = WD_ZERO;
        cmd.acc_op    = ACC_HOLD;
        cmd.res_load  = 1'b0;
        cmd.res_sum   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.mem_op = MEM_WR;
                cmd.wd_sel = WD_ZERO;
                cmd.l_op   = L_INC;
            end
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.item_load = s_valid;
            end
            ST_DECODE: begin
                cmd.acc_op = ACC_ZERO;
                unique case (status.op) inside
                    OP_LOAD, OP_MODIFY: begin
                        cmd.l_op = L_LEAF;
                    end
                    OP_BUILD: begin
                        cmd.l_op = L_BUILD;
                    end
                    OP_QUERY: begin
                        cmd.l_op = L_LEAF;
                        cmd.r_op = R_QRIGHT;
                    end
                    default: begin
                        cmd.l_op = L_HOLD;
                    end
                endcase
            end
            ST_LEAF_WR: begin
                cmd.mem_op = MEM_WR;
                cmd.wd_sel = WD_VAL;
                cmd.acc_op = ACC_VAL;
            end
            ST_MOD_RD: begin
                cmd.mem_op   = MEM_RD;
                cmd.addr_sel = ADDR_SIB;
            end
            ST_MOD_UP: begin
                cmd.mem_op   = MEM_WR;
                cmd.addr_sel = ADDR_PARENT;
                cmd.wd_sel   = WD_SUM;
                cmd.acc_op   = ACC_ADD_RD;
                cmd.l_op     = L_HALF;
            end
            ST_BLD_CHK: begin
                cmd.l_op = L_HOLD;
            end
            ST_BLD_RDL: begin
                cmd.mem_op   = MEM_RD;
                cmd.addr_sel = ADDR_CHILD_L;
            end
            ST_BLD_RDR: begin
                cmd.mem_op   = MEM_RD;
                cmd.addr_sel = ADDR_CHILD_R;
                cmd.acc_op   = ACC_RD;
            end
            ST_BLD_WR: begin
                cmd.mem_op   = MEM_WR;
                cmd.addr_sel = ADDR_L;
                cmd.wd_sel   = WD_SUM;
                cmd.l_op     = L_DEC;
            end
            ST_QRY_A: begin
                // Fold in the right-edge word read in the previous level, if any.
                cmd.acc_op = ACC_ADD_PEND;
                if (status.l_lt_r && status.l_odd) begin
                    cmd.mem_op   = MEM_RD;
                    cmd.addr_sel = ADDR_L;
                    cmd.l_op     = L_INC;
                end
            end
            ST_QRY_B: begin
                cmd.acc_op = ACC_ADD_PEND;
                cmd.l_op   = L_HALF;
                cmd.r_op   = R_HALF;
                if (status.r_odd) begin
                    cmd.mem_op   = MEM_RD;
                    cmd.addr_sel = ADDR_R_EVEN;
                end
            end
            ST_FINISH: begin
                cmd.res_load = status.out_free;
                cmd.res_sum  = (status.op == OP_QUERY) && !status.item_err;
            end
            default: begin
                cmd.res_load = 1'b0;
            end
        endcase
    end

    `STSUM_CHECK(a_no_write_in_query, (state_reg == ST_QRY_A || state_reg == ST_QRY_B), cmd.mem_op != MEM_WR, "node store written during a query")
    `STSUM_CHECK_NEXT(a_finish_to_idle, (state_reg == ST_FINISH && status.out_free), state_reg == ST_IDLE, "result delivered but controller did not return to idle")

endmodule

@@ sv/stsum_dp.sv @@
// Datapath: node store, pointers, accumulator, leaf count register and result register.
`include "segment_tree_range_sum_core_defines.svh"

module stsum_dp
    import stsum_pkg::*;
#(
    parameter int unsigned MAX_LEAVES = DEF_MAX_LEAVES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_leaf_count,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  dp_cmd_t          cmd,
    output dp_status_t       status
);

    localparam int unsigned Depth = 2 * MAX_LEAVES;
    localparam int AW = $clog2(Depth);
    localparam int CW = $clog2(Depth + 1);
    localparam int NW = $clog2(MAX_LEAVES + 1);

    logic [NW-1:0]    n_reg;
    logic [NW-1:0]    n_next;
    in_item_t         item_reg;
    logic [CW-1:0]    l_reg;
    logic [CW-1:0]    l_next;
    logic [CW-1:0]    r_reg;
    logic [CW-1:0]    r_next;
    logic [VAL_W-1:0] acc_reg;
    logic [VAL_W-1:0] acc_next;
    logic [VAL_W-1:0] rd_data_reg;
    logic             rd_pend_reg;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_item_t        m_data_reg;
    out_item_t        m_data_next;
    logic [VAL_W-1:0] node_mem [Depth];

    logic [31:0]      cfg_word;
    logic [31:0]      n32;
    logic [31:0]      pos32;
    logic [31:0]      rb32;
    logic             pos_bad;
    logic             qry_bad;
    logic             item_err;
    logic [AW-1:0]    addr;
    logic [VAL_W-1:0] wdata;
    logic [VAL_W-1:0] sum_rd;

    assign cfg_ready = 1'b1;

    // Out-of-range leaf counts are clamped to one and to the maximum.
    always_comb begin
        cfg_word = 32'(cfg_leaf_count);
        if (cfg_word == 32'd0) begin
            n_next = NW'(1);
        end else if (cfg_word > 32'(MAX_LEAVES)) begin
            n_next = NW'(MAX_LEAVES);
        end else begin
            n_next = NW'(cfg_word);
        end
    end

    assign n32    = 32'(n_reg);
    assign pos32  = 32'(item_reg.position);
    assign rb32   = 32'(item_reg.right_bound);
    assign pos_bad = pos32 >= n32;
    assign qry_bad = (rb32 > n32) || (pos32 > rb32);
    assign sum_rd  = acc_reg + rd_data_reg;

    always_comb begin
        unique case (op_t'(item_reg.opcode)) inside
            OP_LOAD, OP_MODIFY: item_err = pos_bad;
            OP_QUERY:           item_err = qry_bad;
            default:            item_err = 1'b0;
        endcase
    end

    always_comb begin
        case (cmd.l_op)
            L_LEAF:  l_next = CW'(n32 + pos32);
            L_BUILD: l_next = CW'(n32 - 32'd1);
            L_INC:   l_next = l_reg + CW'(1);
            L_DEC:   l_next = l_reg - CW'(1);
            L_HALF:  l_next = l_reg >> 1;
            default: l_next = l_reg;
        endcase
    end

    always_comb begin
        case (cmd.r_op)
            R_QRIGHT: r_next = CW'(n32 + rb32);
            R_HALF:   r_next = r_reg >> 1;
            default:  r_next = r_reg;
        endcase
    end

    always_comb begin
        case (cmd.addr_sel)
            ADDR_SIB:     addr = l_reg[AW-1:0] ^ AW'(1);
            ADDR_CHILD_L: addr = {l_reg[AW-2:0], 1'b0};
            ADDR_CHILD_R: addr = {l_reg[AW-2:0], 1'b1};
            ADDR_PARENT:  addr = AW'(l_reg >> 1);
            ADDR_R_EVEN:  addr = {r_reg[AW-1:1], 1'b0};
            default:      addr = l_reg[AW-1:0];
        endcase
    end

    always_comb begin
        case (cmd.wd_sel)
            WD_VAL:  wdata = item_reg.leaf_value;
            WD_SUM:  wdata = sum_rd;
            default: wdata = '0;
        endcase
    end

    always_comb begin
        case (cmd.acc_op)
            ACC_ZERO:     acc_next = '0;
            ACC_VAL:      acc_next = item_reg.leaf_value;
            ACC_RD:       acc_next = rd_data_reg;
            ACC_ADD_RD:   acc_next = sum_rd;
            ACC_ADD_PEND: acc_next = rd_pend_reg ? sum_rd : acc_reg;
            default:      acc_next = acc_reg;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (cmd.res_load) begin
            m_valid_next          = 1'b1;
            m_data_next.range_sum = cmd.res_sum ? acc_reg : '0;
            m_data_next.error     = item_err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg       <= NW'(MAX_LEAVES);
            l_reg       <= '0;
            r_reg       <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                n_reg <= n_next;
            end
            l_reg       <= l_next;
            r_reg       <= r_next;
            rd_pend_reg <= (cmd.mem_op == MEM_RD);
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            item_reg <= s_data;
        end
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_op == MEM_WR) begin
            node_mem[addr] <= wdata;
        end
        if (cmd.mem_op == MEM_RD) begin
            rd_data_reg <= node_mem[addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.op       = op_t'(item_reg.opcode);
    assign status.item_err = item_err;
    assign status.l_gt1    = l_reg > CW'(1);
    assign status.l_gt3    = l_reg > CW'(3);
    assign status.l_zero   = l_reg == '0;
    assign status.l_eq1    = l_reg == CW'(1);
    assign status.l_lt_r   = l_reg < r_reg;
    assign status.l_odd    = l_reg[0];
    assign status.r_odd    = r_reg[0];
    assign status.clr_last = l_reg == CW'(Depth - 1);
    assign status.out_free = !m_valid_reg || m_ready;

    `STSUM_CHECK(a_no_result_overwrite, cmd.res_load, (!m_valid_reg || m_ready), "result word overwritten before it was taken")
    `STSUM_CHECK(a_error_gives_zero, (m_valid_reg && m_data_reg.error), m_data_reg.range_sum == '0, "error result carries a nonzero sum")
    `STSUM_CHECK(a_pointer_in_store, 1'b1, l_reg <= CW'(Depth), "node pointer ran past the store")

endmodule

@@ sv/segment_tree_range_sum_core.sv @@
// Top level of the segment tree range sum core: controller and datapath.
//
//   Channel  Ports                                 Moves
//   config   cfg_valid, cfg_ready, cfg_leaf_count  leaf count word
//   input    s_valid, s_ready, s_data              one operation word
//   output   m_valid, m_ready, m_data              one result word per operation
//
// After reset a clearing pass zeroes node store entries 0 to 2*MAX_LEAVES-1, one entry
// a cycle; no input word is taken until it ends. Load writes the leaf; modify also
// reads the sibling and writes the parent at each level up to the root; query works level
// by level; build sums nodes leaf_count-1 down to 1; an error word skips to its result.
// Every step is bounded by the single read or write the node store does per cycle.
// One word is worked at a time; a finished result waits in the output register
// while the next word is taken, and a stalled output holds back the following result.
`include "segment_tree_range_sum_core_defines.svh"

module segment_tree_range_sum_core
    import stsum_pkg::*;
#(
    parameter int unsigned MAX_LEAVES = DEF_MAX_LEAVES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_leaf_count,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    stsum_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    stsum_dp #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_leaf_count (cfg_leaf_count),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cmd            (cmd),
        .status         (status)
    );

    `STSUM_CHECK_NEXT(a_accept_starts_work, (s_valid && s_ready), !s_ready, "input taken twice")

endmodule

@@ test/segment_tree_sum_checker.sv @@
// Channel monitor that predicts each segment tree result and compares it with the block's output.
`timescale 1ns / 1ps

module segment_tree_sum_checker
    import stsum_pkg::*;
#(
    parameter int unsigned MAX_LEAVES = DEF_MAX_LEAVES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_leaf_count,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_item_t         s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_item_t        m_data,
    output int               mismatch_count,
    output int               sums_outstanding
);

    logic [31:0] tree [0:2*MAX_LEAVES-1];
    int unsigned leaves;
    out_item_t   sums_due [$];

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Applies one operation word to the shadow tree and returns the result it must give.
    function automatic out_item_t tree_apply(input in_item_t w);
        out_item_t   res;
        logic [31:0] acc;
        int unsigned pos;
        int unsigned rb;
        int unsigned p;
        int unsigned l;
        int unsigned r;
        res = '0;
        acc = '0;
        pos = 32'(w.position);
        rb  = 32'(w.right_bound);
        case (op_t'(w.opcode)) inside
            OP_LOAD, OP_MODIFY: begin
                if (pos >= leaves) begin
                    res.error = 1'b1;
                end else begin
                    p = leaves + pos;
                    tree[p] = w.leaf_value;
                    if (op_t'(w.opcode) == OP_MODIFY) begin
                        while (p > 1) begin
                            tree[p >> 1] = tree[p] + tree[p ^ 1];
                            p = p >> 1;
                        end
                    end
                end
            end
            OP_BUILD: begin
                for (int unsigned i = leaves - 1; i > 0; i--)
                    tree[i] = tree[2*i] + tree[2*i+1];
            end
            default: begin
                if (rb > leaves || pos > rb) begin
                    res.error = 1'b1;
                end else begin
                    l = leaves + pos;
                    r = leaves + rb;
                    while (l < r) begin
                        if ((l & 1) != 0) begin
                            acc = acc + tree[l];
                            l++;
                        end
                        if ((r & 1) != 0) begin
                            r--;
                            acc = acc + tree[r];
                        end
                        l = l >> 1;
                        r = r >> 1;
                    end
                end
            end
        endcase
        res.range_sum = acc;
        return res;
    endfunction

    always @(posedge aclk) begin
        out_item_t   want;
        int unsigned cfg_val;
        if (!aresetn) begin
            for (int k = 0; k < 2*MAX_LEAVES; k++)
                tree[k] = '0;
            leaves = MAX_LEAVES;
            sums_due.delete();
            mismatch_count = 0;
        end else begin
            // A result can never leave in the cycle its word is taken, so compare first.
            if (m_valid && m_ready) begin
                if (sums_due.size() == 0) begin
                    flag_mismatch($sformatf("result word with none expected (sum %0d err %0b)",
                                            m_data.range_sum, m_data.error));
                end else begin
                    want = sums_due.pop_front();
                    if (m_data.range_sum !== want.range_sum)
                        flag_mismatch($sformatf("range_sum %0d, expected %0d",
                                                m_data.range_sum, want.range_sum));
                    if (m_data.error !== want.error)
                        flag_mismatch($sformatf("error %0b, expected %0b",
                                                m_data.error, want.error));
                end
            end
            if (cfg_valid && cfg_ready) begin
                cfg_val = 32'(cfg_leaf_count);
                if (cfg_val == 0)
                    leaves = 1;
                else if (cfg_val > MAX_LEAVES)
                    leaves = MAX_LEAVES;
                else
                    leaves = cfg_val;
            end
            if (s_valid && s_ready)
                sums_due.push_back(tree_apply(s_data));
        end
        sums_outstanding <= sums_due.size();
    end

endmodule

@@ test/segment_tree_range_sum_core_tb.sv @@
// Stimulus and verdict for the segment tree range sum core, checked by a separate monitor.
`timescale 1ns / 1ps

module segment_tree_range_sum_core_tb
    import stsum_pkg::*;
();

    localparam int NUM_PHASES = 12;
    localparam int LONG_HOLD  = 400;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_leaf_count;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;

    int mismatches;
    int results_due;
    int long_holds_asked = 0;
    int burst_left = 1;
    bit tx_live = 1'b0;

    // Raw leaf count written per phase; 2000 exercises the clamp to the maximum.
    int unsigned plan_leaves [NUM_PHASES] = '{2, 5, 16, 1, 33, 100, 7, 2000, 1024, 64, 13, 1};

    always #5 aclk = ~aclk;

    segment_tree_range_sum_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_leaf_count (cfg_leaf_count),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

    segment_tree_sum_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_leaf_count   (cfg_leaf_count),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .mismatch_count   (mismatches),
        .sums_outstanding (results_due)
    );

    function automatic in_item_t make_op(input op_t op, input int unsigned pos,
                                         input int unsigned rb, input logic [31:0] val);
        in_item_t w;
        w.opcode      = op;
        w.position    = POS_W'(pos);
        w.right_bound = RB_W'(rb);
        w.leaf_value  = val;
        return w;
    endfunction

    function automatic logic [31:0] random_leaf_value();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 15);
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Mostly in-range positions and well-formed ranges, with some out-of-range noise.
    function automatic in_item_t random_op(input int unsigned n, input int unsigned build_pct);
        in_item_t    w;
        int unsigned pick;
        int unsigned lo;
        w.position    = POS_W'($urandom_range(0, 1023));
        w.right_bound = RB_W'($urandom_range(0, 2047));
        w.leaf_value  = random_leaf_value();
        pick = $urandom_range(0, 99);
        if (pick < build_pct)
            w.opcode = OP_BUILD;
        else if (pick < build_pct + 25)
            w.opcode = OP_LOAD;
        else if (pick < build_pct + 55)
            w.opcode = OP_MODIFY;
        else
            w.opcode = OP_QUERY;
        if (w.opcode == OP_LOAD || w.opcode == OP_MODIFY) begin
            if ($urandom_range(0, 9) != 0)
                w.position = POS_W'($urandom_range(0, n - 1));
        end else if (w.opcode == OP_QUERY) begin
            case ($urandom_range(0, 19)) inside
                0, 1: ;
                2: begin
                    w.position    = POS_W'($urandom_range(0, (n > 1023) ? 1023 : n));
                    w.right_bound = RB_W'(w.position);
                end
                3: begin
                    w.position    = POS_W'($urandom_range(0, n - 1));
                    w.right_bound = RB_W'(n + $urandom_range(1, 3));
                end
                4: begin
                    w.position    = '0;
                    w.right_bound = RB_W'(n);
                end
                default: begin
                    lo            = $urandom_range(0, n - 1);
                    w.position    = POS_W'(lo);
                    w.right_bound = RB_W'($urandom_range(lo + 1, n));
                end
            endcase
        end
        return w;
    endfunction

    task automatic sender_rest();
        if (tx_live) begin
            s_valid <= 1'b0;
            tx_live = 1'b0;
        end
    endtask

    // Offers one word, waits for it to be taken, then applies the burst and gap pattern.
    task automatic post_word(input in_item_t w);
        int gap;
        s_data  <= w;
        s_valid <= 1'b1;
        tx_live = 1'b1;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                sender_rest();
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain_results();
        sender_rest();
        do @(posedge aclk); while (results_due != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic cfg_write(input int unsigned v);
        cfg_leaf_count <= CFG_W'(v);
        cfg_valid      <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Result side: stall patterns that change every stretch, plus requested long hold-offs.
    initial begin
        int stretch;
        int mode;
        int holds_done;
        m_ready    = 1'b0;
        holds_done = 0;
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(10, 120);
            repeat (stretch) begin
                @(posedge aclk);
                if (holds_done < long_holds_asked) begin
                    holds_done++;
                    m_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                    m_ready <= 1'b1;
                end else begin
                    case (mode)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= ($urandom_range(0, 1) == 1);
                        2:       m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    initial begin
        #(10_000_000);
        $display("segment_tree_range_sum_core_tb failed");
        $finish;
    end

    initial begin
        int unsigned n;
        int          count;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_leaf_count = '0;
        s_valid        = 1'b0;
        s_data         = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Full tree at the reset leaf count: the cleared store, wrap-around and the last leaf.
        post_word(make_op(OP_QUERY, 0, 1024, 32'h0));
        post_word(make_op(OP_LOAD, 1023, 0, 32'h7FFF_FFFF));
        post_word(make_op(OP_LOAD, 0, 2047, 32'h8000_0000));
        post_word(make_op(OP_QUERY, 0, 1024, 32'h0));
        post_word(make_op(OP_BUILD, 1023, 2047, 32'hFFFF_FFFF));
        post_word(make_op(OP_QUERY, 0, 1024, 32'h0));
        post_word(make_op(OP_MODIFY, 1023, 0, 32'hFFFF_FFFF));
        post_word(make_op(OP_QUERY, 1023, 1024, 32'h0));
        post_word(make_op(OP_QUERY, 0, 1024, 32'h0));
        post_word(make_op(OP_QUERY, 5, 5, 32'h0));
        post_word(make_op(OP_QUERY, 0, 2047, 32'h0));
        post_word(make_op(OP_QUERY, 7, 3, 32'h0));
        drain_results();

        // An all-ones write clamps to the maximum; zero clamps to a single leaf.
        cfg_write(2047);
        post_word(make_op(OP_QUERY, 1, 1023, 32'h0));
        drain_results();
        cfg_write(0);
        post_word(make_op(OP_QUERY, 0, 1, 32'h0));
        post_word(make_op(OP_LOAD, 0, 0, 32'd5));
        post_word(make_op(OP_LOAD, 1, 0, 32'd6));
        post_word(make_op(OP_MODIFY, 1023, 0, 32'd7));
        post_word(make_op(OP_BUILD, 0, 0, 32'h0));
        post_word(make_op(OP_QUERY, 0, 1, 32'h0));
        post_word(make_op(OP_MODIFY, 0, 0, 32'd9));
        post_word(make_op(OP_QUERY, 0, 1, 32'h0));
        post_word(make_op(OP_QUERY, 0, 2, 32'h0));
        drain_results();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            cfg_write(plan_leaves[ph]);
            n = (plan_leaves[ph] > 1024) ? 1024 : plan_leaves[ph];
            count = (n >= 512) ? 70 : 115;
            for (int i = 0; i < count; i++) begin
                // Hold the result side off so the block backs up and stalls its input.
                if (ph % 4 == 1 && i == count / 2)
                    long_holds_asked++;
                if (ph % 3 == 2 && i == count / 2)
                    drain_results();
                post_word(random_op(n, (n >= 512) ? 2 : 8));
            end
            drain_results();
        end

        sender_rest();
        do @(posedge aclk); while (results_due != 0);
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && results_due == 0)
            $display("segment_tree_range_sum_core_tb passed");
        else
            $display("segment_tree_range_sum_core_tb failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/stsum_pkg.sv
sv/stsum_ctrl.sv
sv/stsum_dp.sv
sv/segment_tree_range_sum_core.sv
test/segment_tree_sum_checker.sv
test/segment_tree_range_sum_core_tb.sv
